[hw/rtl/bloom_filter_insert_query_top_macros.svh]
// Assertion macros for the Bloom filter block.
// Used by the checker; no other dependencies.
`ifndef BLOOM_FILTER_INSERT_QUERY_TOP_MACROS_SVH
`define BLOOM_FILTER_INSERT_QUERY_TOP_MACROS_SVH

// Same-cycle implication, reset-qualified
`define BFIQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bfiq assertion failed");

// Next-cycle implication, reset-qualified
`define BFIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bfiq assertion failed");

`endif

[hw/rtl/bfiq_pkg.sv]
// Shared constants, types and helpers for the Bloom filter block.
// No dependencies.
package bfiq_pkg;

  // Store geometry
  localparam int MaxBytes = 1024;
  localparam int AddrW    = $clog2(MaxBytes);
  localparam int PosW     = AddrW + 3;
  localparam int NbitsW   = PosW + 1;

  // Field widths
  localparam int HashW     = 32;
  localparam int KeyByteW  = 8;
  localparam int ByteCntW  = 11;
  localparam int HashCntW  = 5;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 11;
  localparam int RemCntW   = $clog2(HashW);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgByteCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHashCount = 1'b1;

  // Actions
  localparam logic ActAdd   = 1'b0;
  localparam logic ActQuery = 1'b1;

  // Remainders handed from the remainder unit to the probe sequencer
  typedef struct packed {
    logic [PosW-1:0] ra;   // hash_a mod nbits
    logic [PosW-1:0] rb;   // hash_b mod nbits
    logic [PosW-1:0] adj;  // (-2^32) mod nbits, added when a probe wraps
  } rem_res_t;

  // One restoring-remainder step: shift in a bit, subtract the modulus if it fits
  function automatic logic [PosW-1:0] rem_step(input logic [PosW-1:0]   r,
                                               input logic              b,
                                               input logic [NbitsW-1:0] n);
    logic [NbitsW-1:0] s;
    logic [NbitsW-1:0] ds;
    s  = {r, b};
    ds = s - n;
    if (s >= n) begin
      return ds[PosW-1:0];
    end
    return s[PosW-1:0];
  endfunction

endpackage

[hw/rtl/bloom_filter_insert_query_top.sv]
// Bloom filter with double hashing: byte hashing, probe sequencer, bit store.
// Depends on bfiq_pkg, bfiq_ram and bfiq_rem.
//
//  channel  | handshake             | words
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid_i/in_stall_o | action, key_byte, byte_present, key_last
//  out      | out_valid_o/out_stall_i | maybe_present (queries only)
//  cfg      | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// A key byte that is not last is folded into the running hashes without a stall. The
// last word of a key then passes through the bit-serial remainder unit and, per
// probe, a read of the bit-store RAM then a write-back for an add, and a query result
// is posted last. After reset a clearing pass zeroes all MaxBytes (1024) rows of the
// store; input is stalled meanwhile. A result waiting on out_stall_i holds the block
// only when the next query result is ready.
module bloom_filter_insert_query_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            in_action_i,
  input  logic [bfiq_pkg::KeyByteW-1:0]   in_key_byte_i,
  input  logic                            in_byte_present_i,
  input  logic                            in_key_last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            out_maybe_present_o,
  input  logic                            cfg_we_i,
  input  logic [bfiq_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bfiq_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import bfiq_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StWrite = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  logic [ByteCntW-1:0] byte_count_q;
  logic [HashCntW-1:0] hash_count_q;
  logic [HashW-1:0]    ha_q, ha_d, hb_q, hb_d;
  logic [HashW-1:0]    probe_q, probe_d, hstep_q, hstep_d;
  logic [PosW-1:0]     pos_q, pos_d, step_q, step_d, adj_q, adj_d;
  logic [HashCntW-1:0] cnt_q, cnt_d;
  logic                act_q, act_d;
  logic                res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic                out_mp_q, out_mp_d;

  logic [ByteCntW-1:0] nbytes;
  logic [NbitsW-1:0]   nbits;
  logic [HashW-1:0]    ha_abs, hb_abs;
  logic [HashW:0]      probe_sum;
  logic [PosW+1:0]     t0, t1, t2, nbits_x;
  logic                rem_start, rem_done;
  rem_res_t            rem_res;
  logic                ram_we;
  logic [AddrW-1:0]    ram_addr;
  logic [7:0]          ram_wdata, ram_rdata, bit_mask;
  logic                hit, last_probe;

  // Store size in use, clamped to the RAM
  assign nbytes = (byte_count_q > ByteCntW'(MaxBytes)) ? ByteCntW'(MaxBytes) : byte_count_q;
  assign nbits  = {nbytes[AddrW:0], 3'b000};

  // Running hashes: x*31 = (x<<5)-x, x*37 = (x<<5)+(x<<2)+x
  always_comb begin
    ha_abs = ha_q;
    hb_abs = hb_q;
    if (in_byte_present_i) begin
      ha_abs = {ha_q[HashW-6:0], 5'b0} - ha_q + HashW'(in_key_byte_i);
      hb_abs = {hb_q[HashW-6:0], 5'b0} + {hb_q[HashW-3:0], 2'b0} + hb_q
               + HashW'(in_key_byte_i);
    end
  end

  // Next probe position, tracking the 2^32 wrap of the raw probe
  assign probe_sum = {1'b0, probe_q} + {1'b0, hstep_q};
  assign nbits_x   = (PosW+2)'(nbits);
  assign t0 = (PosW+2)'(pos_q) + (PosW+2)'(step_q)
              + (probe_sum[HashW] ? (PosW+2)'(adj_q) : '0);
  assign t1 = (t0 >= nbits_x) ? (t0 - nbits_x) : t0;
  assign t2 = (t1 >= nbits_x) ? (t1 - nbits_x) : t1;

  assign bit_mask   = 8'b1 << pos_q[2:0];
  assign hit        = ram_rdata[pos_q[2:0]];
  assign last_probe = ({1'b0, cnt_q} + (HashCntW+1)'(1)) == {1'b0, hash_count_q};

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ha_d        = ha_q;
    hb_d        = hb_q;
    probe_d     = probe_q;
    hstep_d     = hstep_q;
    pos_d       = pos_q;
    step_d      = step_q;
    adj_d       = adj_q;
    cnt_d       = cnt_q;
    act_d       = act_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_mp_d    = out_mp_q;
    rem_start   = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = pos_q[PosW-1:3];
    ram_wdata   = ram_rdata | bit_mask;
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MaxBytes - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          ha_d = ha_abs;
          hb_d = hb_abs;
          if (in_key_last_i) begin
            ha_d    = '0;
            hb_d    = '0;
            probe_d = ha_abs;
            hstep_d = hb_abs;
            act_d   = in_action_i;
            cnt_d   = '0;
            res_d   = 1'b1;
            if (nbytes == '0 || hash_count_q == '0) begin
              state_d = (in_action_i == ActQuery) ? StDone : StIdle;
            end else begin
              rem_start = 1'b1;
              state_d   = StDiv;
            end
          end
        end
      end
      StDiv: begin
        if (rem_done) begin
          pos_d   = rem_res.ra;
          step_d  = rem_res.rb;
          adj_d   = rem_res.adj;
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StWrite;
      end
      StWrite: begin
        if (act_q == ActAdd) begin
          ram_we = 1'b1;
        end
        if (act_q == ActQuery && !hit) begin
          res_d   = 1'b0;
          state_d = StDone;
        end else if (last_probe) begin
          state_d = (act_q == ActQuery) ? StDone : StIdle;
        end else begin
          cnt_d   = cnt_q + HashCntW'(1);
          probe_d = probe_sum[HashW-1:0];
          pos_d   = t2[PosW-1:0];
          state_d = StRead;
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_mp_d    = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ha_q        <= '0;
      hb_q        <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      ha_q        <= ha_d;
      hb_q        <= hb_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= ByteCntW'(1024);
      hash_count_q <= HashCntW'(6);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgByteCount: byte_count_q <= cfg_wdata_i[ByteCntW-1:0];
        CfgHashCount: hash_count_q <= cfg_wdata_i[HashCntW-1:0];
        default:      byte_count_q <= byte_count_q;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    probe_q  <= probe_d;
    hstep_q  <= hstep_d;
    pos_q    <= pos_d;
    step_q   <= step_d;
    adj_q    <= adj_d;
    act_q    <= act_d;
    res_q    <= res_d;
    out_mp_q <= out_mp_d;
  end

  bfiq_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .a_i     (ha_abs),
    .b_i     (hb_abs),
    .nbits_i (nbits),
    .done_o  (rem_done),
    .res_o   (rem_res)
  );

  // Bit store, one byte of filter bits per row
  bfiq_ram #(
    .Width (8),
    .Depth (MaxBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o          = (state_q != StIdle);
  assign out_valid_o         = out_valid_q;
  assign out_maybe_present_o = out_mp_q;

endmodule

[hw/rtl/bfiq_ram.sv]
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module bfiq_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bfiq_rem.sv]
// Bit-serial remainder unit: hash_a, hash_b and 2^32 modulo the bits in use.
// Depends on bfiq_pkg.
module bfiq_rem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [bfiq_pkg::HashW-1:0]       a_i,
  input  logic [bfiq_pkg::HashW-1:0]       b_i,
  input  logic [bfiq_pkg::NbitsW-1:0]      nbits_i,
  output logic                             done_o,
  output bfiq_pkg::rem_res_t               res_o
);
  import bfiq_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [RemCntW-1:0] cnt_q, cnt_d;
  logic [HashW-1:0]   sa_q, sa_d, sb_q, sb_d;
  logic [PosW-1:0]    ra_q, ra_d, rb_q, rb_d, rw_q, rw_d;
  logic [NbitsW-1:0]  adj_full;

  // One dividend bit per cycle for all three remainders
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sa_d   = sa_q;
    sb_d   = sb_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    rw_d   = rw_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sa_d   = a_i;
      sb_d   = b_i;
      ra_d   = '0;
      rb_d   = '0;
      // the leading one of 2^32 is already shifted in (nbits is at least 8)
      rw_d   = PosW'(1);
    end else if (busy_q) begin
      ra_d  = rem_step(ra_q, sa_q[HashW-1], nbits_i);
      rb_d  = rem_step(rb_q, sb_q[HashW-1], nbits_i);
      rw_d  = rem_step(rw_q, 1'b0, nbits_i);
      sa_d  = {sa_q[HashW-2:0], 1'b0};
      sb_d  = {sb_q[HashW-2:0], 1'b0};
      cnt_d = cnt_q + RemCntW'(1);
      if (cnt_q == RemCntW'(HashW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q <= sa_d;
    sb_q <= sb_d;
    ra_q <= ra_d;
    rb_q <= rb_d;
    rw_q <= rw_d;
  end

  // Wrap correction: subtracting 2^32 is adding nbits - (2^32 mod nbits)
  assign adj_full = nbits_i - {1'b0, rw_q};

  assign done_o    = done_q;
  assign res_o.ra  = ra_q;
  assign res_o.rb  = rb_q;
  assign res_o.adj = (rw_q == '0) ? '0 : adj_full[PosW-1:0];

endmodule

[hw/rtl/bfiq_checker.sv]
// Port-level checker for the Bloom filter block, bound to the top level.
// Depends on bfiq_pkg and the assertion macro header.
`include "bloom_filter_insert_query_top_macros.svh"

module bfiq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic in_action_i,
  input logic in_key_last_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic out_maybe_present_o
);
  import bfiq_pkg::*;

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // a stalled result word holds
  `BFIQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_maybe_present_o))
  // mid-key bytes stream without a bubble
  `BFIQ_ASSERT_NEXT(a_byte_stream, clk_i, rst_ni, in_take && !in_key_last_i, !in_stall_o)
  // the end of a query key always keeps the block busy
  `BFIQ_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_take && in_key_last_i && (in_action_i == ActQuery), in_stall_o)
  // a result is only posted from a busy cycle
  `BFIQ_ASSERT_IMPL(a_result_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind bloom_filter_insert_query_top bfiq_checker u_bfiq_checker (.*);
